/* rtl/mffr_pkg.sv */
// Shared types and constants for the motor feedback frame receiver.
`timescale 1ns / 1ps

package mffr_pkg;

    localparam int FRAME_LEN = 18;   // bytes per frame
    localparam int FRAME_WORDS = 9;  // start, seven payload words, checksum
    localparam int COUNT_W = 5;

    localparam logic [15:0] SYNC_RESET = 16'hABCD;
    localparam logic [COUNT_W-1:0] START_COUNT = 5'd2;  // count right after the sync word
    localparam logic [COUNT_W-1:0] LAST_COUNT = 5'd17;  // index of the final frame byte

    // Whole frame, byte 0 in the lowest slot.
    typedef logic [FRAME_LEN-1:0][7:0] frame_t;

    typedef struct packed {
        logic               status;
        logic        [15:0] led_command;
        logic signed [15:0] board_temperature;
        logic signed [15:0] battery_level;
        logic signed [15:0] speed_left;
        logic signed [15:0] speed_right;
        logic signed [15:0] command_two;
        logic signed [15:0] command_one;
    } result_t;

endpackage

/* rtl/mffr_frame_check.sv */
// Frame checker: splits a complete frame into words, checks start word and XOR sum.
`timescale 1ns / 1ps

module mffr_frame_check (
    input  mffr_pkg::frame_t  frame,
    input  logic [15:0]       sync_word,
    output mffr_pkg::result_t result
);
    import mffr_pkg::*;

    logic [FRAME_WORDS-1:0][15:0] words;
    logic [15:0]                  xor_sum;

    always_comb begin
        for (int k = 0; k < FRAME_WORDS; k++) begin
            words[k] = {frame[2*k+1], frame[2*k]};
        end
        xor_sum = '0;
        for (int k = 0; k < FRAME_WORDS - 1; k++) begin
            xor_sum = xor_sum ^ words[k];
        end
    end

    always_comb begin
        result.status            = (words[0] != sync_word) || (xor_sum != words[FRAME_WORDS-1]);
        result.command_one       = words[1];
        result.command_two       = words[2];
        result.speed_right       = words[3];
        result.speed_left        = words[4];
        result.battery_level     = words[5];
        result.board_temperature = words[6];
        result.led_command       = words[7];
    end

endmodule

/* rtl/motor_feedback_frame_receiver.sv */
// Top level: rebuilds 18-byte motor feedback frames from a byte stream.
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+---------------------------------------------
//  s_       | in  | s_tvalid / s_tready  | s_tdata[7:0] rx_byte
//  m_       | out | m_tvalid / m_tready  | m_tdata[111:0] seven payload words, m_tuser status
//  cfg_     | in  | cfg_valid / cfg_ready| cfg_data[15:0] sync_word
//
// One byte per beat, one beat per cycle while s_tready is high; the frame result is
// registered in the cycle after the final byte is accepted, into the single result
// register, so bytes keep being taken while the result is drained by m_tready.
// s_tready drops only while a result waits in that register and m_tready is low.
// aresetn is synchronous, active low: clears the byte count, previous byte, result
// valid and reloads sync_word to 0xABCD. Frame byte storage is not cleared.
`timescale 1ns / 1ps

module motor_feedback_frame_receiver (
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,     // [7:0] rx_byte

    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,     // [15:0] command_one, [31:16] command_two,
                                      // [47:32] speed_right, [63:48] speed_left,
                                      // [79:64] battery_level, [95:80] board_temperature,
                                      // [111:96] led_command
    output logic         m_tuser,     // [0] status: 0 ok, 1 start/checksum error

    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [15:0]  cfg_data     // [15:0] sync_word
);
    import mffr_pkg::*;

    // State
    logic [15:0]        sync_word_reg;
    logic [7:0]         prev_byte_reg;
    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [7:0]         frame_reg [LAST_COUNT];  // bytes 0..16; byte 17 comes straight in
    logic               m_tvalid_reg, m_tvalid_next;
    result_t            result_reg;

    // Per-beat decode
    logic    accept;
    logic    is_sync;
    logic    store_byte;
    logic    frame_done;
    logic    out_load;
    frame_t  frame_view;
    result_t check_result;

    assign cfg_ready = 1'b1;

    // Take a byte unless a finished result is stuck in the output register.
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Sync word: previous byte low, current byte high. Restart beats everything.
    assign is_sync    = ({s_tdata, prev_byte_reg} == sync_word_reg);
    assign store_byte = !is_sync && (byte_count_reg >= START_COUNT)
                        && (byte_count_reg < LAST_COUNT);
    assign frame_done = !is_sync && (byte_count_reg == LAST_COUNT);
    assign out_load   = accept && frame_done;

    // Frame as seen on the completing beat: stored bytes plus the incoming one.
    always_comb begin
        for (int i = 0; i < FRAME_LEN - 1; i++) begin
            frame_view[i] = frame_reg[i];
        end
        frame_view[FRAME_LEN-1] = s_tdata;
    end

    mffr_frame_check u_check (
        .frame     (frame_view),
        .sync_word (sync_word_reg),
        .result    (check_result)
    );

    always_comb begin
        byte_count_next = byte_count_reg;
        if (accept) begin
            if (is_sync) begin
                byte_count_next = START_COUNT;
            end else if (store_byte) begin
                byte_count_next = byte_count_reg + 1'b1;
            end else if (frame_done) begin
                byte_count_next = '0;
            end
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_word_reg  <= SYNC_RESET;
            prev_byte_reg  <= '0;
            byte_count_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                sync_word_reg <= cfg_data;
            end
            if (accept) begin
                prev_byte_reg <= s_tdata;
            end
            byte_count_reg <= byte_count_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // Frame storage and result register, payload only
    always_ff @(posedge aclk) begin
        if (accept) begin
            if (is_sync) begin
                frame_reg[0] <= prev_byte_reg;
                frame_reg[1] <= s_tdata;
            end else if (store_byte) begin
                frame_reg[byte_count_reg] <= s_tdata;
            end
        end
        if (out_load) begin
            result_reg <= check_result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = result_reg.status;
    assign m_tdata  = {result_reg.led_command,
                       result_reg.board_temperature,
                       result_reg.battery_level,
                       result_reg.speed_left,
                       result_reg.speed_right,
                       result_reg.command_two,
                       result_reg.command_one};

    // Byte count is 0 or 2..17 between beats.
    a_count_range : assert property (@(posedge aclk) disable iff (!aresetn)
        (byte_count_reg != 5'd1) && (byte_count_reg <= LAST_COUNT))
        else $error("byte count out of range");

    // A new result only appears after an accepted beat.
    a_result_source : assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(s_tvalid && s_tready))
        else $error("result without an accepted beat");

    // Emitting a frame closes it.
    a_done_clears : assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (byte_count_reg == '0))
        else $error("count not cleared after frame");

    // Sync pair always (re)opens a frame.
    a_sync_opens : assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && is_sync) |=> (byte_count_reg == START_COUNT))
        else $error("sync did not restart frame");

    // Input stalls only behind a waiting result.
    a_stall_cause : assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid_reg && !m_tready))
        else $error("input stalled without a pending result");

endmodule
